[src/png_scanline_unfilter_core_defines.svh]
// Assertion macros shared by the checker files.
`ifndef PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is applied.
`define PUS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("png unfilter check failed (same cycle)");

// Next-cycle implication, off while reset is applied.
`define PUS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("png unfilter check failed (next cycle)");

// Next-cycle implication that also holds across reset.
`define PUS_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("png unfilter check failed (reset)");

`endif

[src/pus_pkg.sv]
`default_nettype none

package pus_pkg;

  // Storage limits
  localparam int MAX_ROW_BYTES = 8192;
  localparam int MAX_BPP       = 4;

  // Widths
  localparam int COL_W      = $clog2(MAX_ROW_BYTES);
  localparam int SLOT_W     = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
  localparam int BPP_W      = 3;
  localparam int LEN_W      = 14;
  localparam int ROWS_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BPP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_ROWS = 2'd2;

  // Filter type codes
  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  // Per-item control carried alongside a data byte
  typedef struct packed {
    logic [7:0]        filt;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic              have_left;
    logic              first_row;
    logic              row_end;
    logic              image_end;
  } item_info_t;

endpackage

`default_nettype wire

[src/png_scanline_unfilter_core.sv]
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_stall, in_stream_byte             | in
//  result  | out_valid, out_stall, out_pixel_byte,          | out
//          | out_row_end, out_image_end                     |
//  config  | cfg_we, cfg_index, cfg_wdata                   | in
//
//  One item per cycle sustained while out_stall is low; a data byte is held first
//  in the stage register and then in the output register, from which it leaves.
//  Filter-type bytes are accepted but give no result.
//  The single-port-pair row store (one read, one write each cycle) sets the rate.
//  Synchronous reset clears control state; the row store is not cleared, the
//  first row of every image uses zero for its up values.
//  out_stall backs up through the stage and output registers; in_stall rises
//  only when both hold an item.
`default_nettype none

module png_scanline_unfilter_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_stream_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_pixel_byte,
  output logic                                out_row_end,
  output logic                                out_image_end,
  input  wire logic                           cfg_we,
  input  wire logic [pus_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pus_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                s1_valid_r, s1_valid_nxt;
  logic [7:0]          s1_byte_r;
  pus_pkg::item_info_t s1_info_r;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r;
  logic                out_rend_r, out_iend_r;

  logic                out_free, s1_move, s1_free, accept, data_acc, is_data;
  pus_pkg::item_info_t in_info;
  logic [7:0]          up_raw, recon;

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;
  assign data_acc = accept && is_data;

  pus_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_byte   (in_stream_byte),
    .is_data   (is_data),
    .info      (in_info)
  );

  // Up value is read as the item enters the stage register
  pus_row_ram u_row_ram (
    .clk     (clk),
    .rd_en   (data_acc),
    .rd_addr (in_info.col),
    .wr_en   (s1_move),
    .wr_addr (s1_info_r.col),
    .wr_data (recon),
    .rd_data (up_raw)
  );

  pus_recon u_recon (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (s1_move),
    .filt_byte (s1_byte_r),
    .info      (s1_info_r),
    .up_raw    (up_raw),
    .recon     (recon)
  );

  // Stage and output valid flags
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (data_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (data_acc) begin
      s1_byte_r <= in_stream_byte;
      s1_info_r <= in_info;
    end
    if (s1_move) begin
      out_byte_r <= recon;
      out_rend_r <= s1_info_r.row_end;
      out_iend_r <= s1_info_r.image_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_byte = out_byte_r;
  assign out_row_end    = out_rend_r;
  assign out_image_end  = out_iend_r;

endmodule

`default_nettype wire

[src/pus_ctrl.sv]
`default_nettype none

// Config registers, stream position counters and per-item control.
module pus_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pus_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pus_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                          accept,
  input  wire logic [7:0]                    in_byte,
  output logic                               is_data,
  output pus_pkg::item_info_t                info
);

  // column mod 3: base-4 digits sum to the same residue
  function automatic logic [1:0] mod3(input logic [pus_pkg::COL_W-1:0] v);
    logic [pus_pkg::COL_W+1:0] w;
    logic [4:0] s;
    logic [2:0] t;
    w = {2'b00, v};
    s = '0;
    for (int i = 0; i < (pus_pkg::COL_W + 2) / 2; i++) begin
      s = s + 5'(w[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  logic [pus_pkg::BPP_W-1:0]  bpp_r;
  logic [pus_pkg::LEN_W-1:0]  len_r;
  logic [pus_pkg::ROWS_W-1:0] rows_r;
  logic                       await_r, await_nxt;
  logic [7:0]                 filt_r, filt_nxt;
  logic [pus_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [pus_pkg::ROWS_W-1:0] row_r, row_nxt;

  logic [pus_pkg::BPP_W-1:0]  bpp_eff;
  logic [pus_pkg::LEN_W-1:0]  len_eff;
  logic [pus_pkg::ROWS_W-1:0] rows_eff;
  logic [pus_pkg::SLOT_W-1:0] slot;
  logic                       rend, iend;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r  <= pus_pkg::BPP_W'(1);
      len_r  <= pus_pkg::LEN_W'(1);
      rows_r <= pus_pkg::ROWS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        pus_pkg::CFG_BPP:      bpp_r  <= cfg_wdata[pus_pkg::BPP_W-1:0];
        pus_pkg::CFG_ROW_LEN:  len_r  <= cfg_wdata[pus_pkg::LEN_W-1:0];
        pus_pkg::CFG_IMG_ROWS: rows_r <= cfg_wdata[pus_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp config to legal ranges
  always_comb begin
    if (bpp_r == '0) begin
      bpp_eff = pus_pkg::BPP_W'(1);
    end else if (bpp_r > pus_pkg::BPP_W'(pus_pkg::MAX_BPP)) begin
      bpp_eff = pus_pkg::BPP_W'(pus_pkg::MAX_BPP);
    end else begin
      bpp_eff = bpp_r;
    end
    if (len_r == '0) begin
      len_eff = pus_pkg::LEN_W'(1);
    end else if (len_r > pus_pkg::LEN_W'(pus_pkg::MAX_ROW_BYTES)) begin
      len_eff = pus_pkg::LEN_W'(pus_pkg::MAX_ROW_BYTES);
    end else begin
      len_eff = len_r;
    end
    rows_eff = (rows_r == '0) ? pus_pkg::ROWS_W'(1) : rows_r;
  end

  // Pixel slot of the current column
  always_comb begin
    case (bpp_eff)
      3'd2:    slot = pus_pkg::SLOT_W'(col_r[0]);
      3'd3:    slot = pus_pkg::SLOT_W'(mod3(col_r));
      3'd4:    slot = pus_pkg::SLOT_W'(col_r[1:0]);
      default: slot = '0;
    endcase
  end

  // Row and image end detection
  assign rend = (pus_pkg::LEN_W'(col_r) + pus_pkg::LEN_W'(1)) >= len_eff;
  assign iend = rend &&
                (({1'b0, row_r} + (pus_pkg::ROWS_W+1)'(1)) >= {1'b0, rows_eff});

  // Item control for the byte at the input
  assign is_data        = !await_r;
  assign info.filt      = filt_r;
  assign info.col       = col_r;
  assign info.slot      = slot;
  assign info.have_left = (pus_pkg::LEN_W'(col_r) >= pus_pkg::LEN_W'(bpp_eff));
  assign info.first_row = (row_r == '0);
  assign info.row_end   = rend;
  assign info.image_end = iend;

  // Position counters advance per accepted item
  always_comb begin
    await_nxt = await_r;
    filt_nxt  = filt_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (accept) begin
      if (await_r) begin
        filt_nxt  = in_byte;
        col_nxt   = '0;
        await_nxt = 1'b0;
      end else if (rend) begin
        await_nxt = 1'b1;
        col_nxt   = '0;
        row_nxt   = iend ? '0 : row_r + pus_pkg::ROWS_W'(1);
      end else begin
        col_nxt = col_r + pus_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b1;
      filt_r  <= pus_pkg::FILT_NONE;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      await_r <= await_nxt;
      filt_r  <= filt_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule

`default_nettype wire

[src/pus_row_ram.sv]
`default_nettype none

// Prior-row store: one write and one registered read per cycle.
// A read and write to the same address in one cycle returns the new data.
module pus_row_ram (
  input  wire logic                      clk,
  input  wire logic                      rd_en,
  input  wire logic [pus_pkg::COL_W-1:0] rd_addr,
  input  wire logic                      wr_en,
  input  wire logic [pus_pkg::COL_W-1:0] wr_addr,
  input  wire logic [7:0]                wr_data,
  output logic [7:0]                     rd_data
);

  logic [7:0] mem [pus_pkg::MAX_ROW_BYTES];
  logic [7:0] mem_q_r;
  logic [7:0] fwd_data_r;
  logic       fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, with write forwarding on an address match
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : mem_q_r;

endmodule

`default_nettype wire

[src/pus_recon.sv]
`default_nettype none

// Predictor and add, plus the left / up-left byte registers.
module pus_recon (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                upd,
  input  wire logic [7:0]          filt_byte,
  input  wire pus_pkg::item_info_t info,
  input  wire logic [7:0]          up_raw,
  output logic [7:0]               recon
);

  // Paeth: nearest of left, up, up-left to left+up-upleft; ties prefer that order
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] sa, sb, sc, ea, eb, ec;
    logic [9:0]        da, db, dc;
    logic [7:0]        res;
    sa = signed'({2'b00, a});
    sb = signed'({2'b00, b});
    sc = signed'({2'b00, c});
    ea = sb - sc;
    eb = sa - sc;
    ec = sa + sb - sc - sc;
    da = (ea < 0) ? 10'(-ea) : 10'(ea);
    db = (eb < 0) ? 10'(-eb) : 10'(eb);
    dc = (ec < 0) ? 10'(-ec) : 10'(ec);
    if (da <= db && da <= dc) begin
      res = a;
    end else if (db <= dc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

  logic [7:0] left_r   [pus_pkg::MAX_BPP];
  logic [7:0] upleft_r [pus_pkg::MAX_BPP];
  logic [7:0] a, b, c;
  logic [8:0] avg_sum;

  // Operands, zeroed at row start and on the first row
  assign b = info.first_row ? 8'd0 : up_raw;
  assign a = info.have_left ? left_r[info.slot] : 8'd0;
  assign c = (info.have_left && !info.first_row) ? upleft_r[info.slot] : 8'd0;
  assign avg_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (info.filt)
      pus_pkg::FILT_SUB:   recon = filt_byte + a;
      pus_pkg::FILT_UP:    recon = filt_byte + b;
      pus_pkg::FILT_AVG:   recon = filt_byte + avg_sum[8:1];
      pus_pkg::FILT_PAETH: recon = filt_byte + paeth(a, b, c);
      default:             recon = filt_byte;
    endcase
  end

  // Keep the last pixel's bytes and their up values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pus_pkg::MAX_BPP; i++) begin
        left_r[i]   <= 8'd0;
        upleft_r[i] <= 8'd0;
      end
    end else if (upd) begin
      left_r[info.slot]   <= recon;
      upleft_r[info.slot] <= b;
    end
  end

endmodule

`default_nettype wire

[src/pus_checker.sv]
`default_nettype none
`include "png_scanline_unfilter_core_defines.svh"

// Port-level checks on the unfilter core.
module pus_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic [7:0]                     in_stream_byte,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [7:0]                     out_pixel_byte,
  input wire logic                           out_row_end,
  input wire logic                           out_image_end,
  input wire logic                           cfg_we,
  input wire logic [pus_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [pus_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Reset empties the output
  `PUS_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

  // With the output empty there is always room at the input
  `PUS_ASSERT_NOW(a_room_when_empty, !out_valid, !in_stall)

  // Image end only on a row end
  `PUS_ASSERT_NOW(a_iend_on_rend, out_valid && out_image_end, out_row_end)

  // A stalled result holds
  `PUS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_pixel_byte) && $stable(out_row_end)
                   && $stable(out_image_end))

endmodule

bind png_scanline_unfilter_core pus_checker u_pus_checker (.*);

`default_nettype wire

[dv/png_scanline_unfilter_core_tb.sv]
`default_nettype none

module png_scanline_unfilter_core_tb;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_EVERY    = 400;
  localparam int unsigned HOLD_AT       = 150;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_BYTES  = 650;
  localparam int unsigned LONG_BYTES    = 100;

  typedef enum logic [0:0] {OP_BYTE, OP_CFG} feed_op_t;

  typedef struct {
    feed_op_t                       op;
    logic [7:0]                     data;
    logic [pus_pkg::CFG_IDX_W-1:0]  idx;
    logic [pus_pkg::CFG_DATA_W-1:0] wdata;
  } feed_item_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     in_stream_byte = 8'h00;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [7:0]                     out_pixel_byte;
  logic                           out_row_end;
  logic                           out_image_end;
  logic                           cfg_we = 1'b0;
  logic [pus_pkg::CFG_IDX_W-1:0]  cfg_index = pus_pkg::CFG_BPP;
  logic [pus_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  png_scanline_unfilter_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_byte (out_pixel_byte),
    .out_row_end    (out_row_end),
    .out_image_end  (out_image_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Pending items and expected reconstructed bytes
  feed_item_t  feed_q[$];
  pixel_t      recon_q[$];
  int unsigned fed_bytes = 0;
  int unsigned taken_bytes = 0;
  int unsigned out_count = 0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_cycles = 0;
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;

  // Unfilter state mirrored by the predictor
  logic [7:0]                 up_row [pus_pkg::MAX_ROW_BYTES];
  logic [7:0]                 left_q [pus_pkg::MAX_BPP];
  logic [7:0]                 upleft_q [pus_pkg::MAX_BPP];
  int unsigned                col_q = 0;
  int unsigned                row_q = 0;
  logic [7:0]                 cur_filt = pus_pkg::FILT_NONE;
  bit                         want_filt = 1'b1;
  logic [pus_pkg::BPP_W-1:0]  p_bpp = 1;
  logic [pus_pkg::LEN_W-1:0]  p_len = 1;
  logic [pus_pkg::ROWS_W-1:0] p_rows = 1;

  // Stream position as seen while building stimulus
  bit                         g_await = 1'b1;
  int unsigned                g_col = 0;
  int unsigned                g_row = 0;
  int unsigned                g_hw = 0;
  logic [pus_pkg::LEN_W-1:0]  g_len = 1;
  logic [pus_pkg::ROWS_W-1:0] g_rows = 1;

  // Idle draws for both sides
  int unsigned tx_gap = 0;
  int unsigned tx_run = 0;
  bit          tx_calm = 1'b0;
  int unsigned rx_gap = 0;
  int unsigned rx_run = 0;
  bit          rx_calm = 1'b0;

  initial begin
    for (int i = 0; i < pus_pkg::MAX_BPP; i++) begin
      left_q[i] = 8'h00;
      upleft_q[i] = 8'h00;
    end
  end

  function automatic int unsigned clamp_bpp(input logic [pus_pkg::BPP_W-1:0] v);
    if (v == 0) return 1;
    if (v > pus_pkg::MAX_BPP) return pus_pkg::MAX_BPP;
    return v;
  endfunction

  function automatic int unsigned clamp_len(input logic [pus_pkg::LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > pus_pkg::MAX_ROW_BYTES) return pus_pkg::MAX_ROW_BYTES;
    return v;
  endfunction

  function automatic int unsigned clamp_rows(input logic [pus_pkg::ROWS_W-1:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  // Paeth predictor: left wins ties, then up, then up-left
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int p, da, db, dc;
    p  = int'(a) + int'(b) - int'(c);
    da = p - int'(a);
    db = p - int'(b);
    dc = p - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Reconstruct one accepted stream byte and queue the expected output
  function automatic void unfilter_step(input logic [7:0] x);
    int unsigned bpp, len, rows, slot;
    logic [7:0] a, b, c, r;
    logic [8:0] avg;
    logic have_left, first_row, rend, iend;
    pixel_t res;
    if (want_filt) begin
      cur_filt = x;
      col_q = 0;
      want_filt = 1'b0;
      return;
    end
    bpp = clamp_bpp(p_bpp);
    len = clamp_len(p_len);
    rows = clamp_rows(p_rows);
    slot = col_q % bpp;
    have_left = (col_q >= bpp);
    first_row = (row_q == 0);
    a = have_left ? left_q[slot] : 8'h00;
    b = first_row ? 8'h00 : up_row[col_q];
    c = (have_left && !first_row) ? upleft_q[slot] : 8'h00;
    avg = ({1'b0, a} + {1'b0, b}) >> 1;
    case (cur_filt)
      pus_pkg::FILT_NONE:  r = x;
      pus_pkg::FILT_SUB:   r = x + a;
      pus_pkg::FILT_UP:    r = x + b;
      pus_pkg::FILT_AVG:   r = x + avg[7:0];
      pus_pkg::FILT_PAETH: r = x + paeth_pick(a, b, c);
      default:             r = x;
    endcase
    left_q[slot] = r;
    upleft_q[slot] = b;
    up_row[col_q] = r;
    rend = (col_q + 1 >= len);
    iend = rend && (row_q + 1 >= rows);
    if (rend) begin
      want_filt = 1'b1;
      col_q = 0;
      row_q = iend ? 0 : ((row_q + 1) & 16'hFFFF);
    end else begin
      col_q++;
    end
    res.pixel = r;
    res.row_end = rend;
    res.image_end = iend;
    recon_q.push_back(res);
  endfunction

  // Per-item wait, with occasional runs of back-to-back items
  task automatic draw_gap(inout int unsigned run, inout bit calm,
                          output int unsigned gap);
    if (run == 0) begin
      run = $urandom_range(20, 80);
      calm = ($urandom_range(0, 3) == 0);
    end
    run--;
    gap = calm ? 0 : $urandom_range(0, 19);
  endtask

  // Stimulus building: track row/column so the row store is never read unwritten
  task automatic push_byte(input logic [7:0] v);
    feed_item_t s;
    s.op = OP_BYTE;
    s.data = v;
    s.idx = pus_pkg::CFG_BPP;
    s.wdata = '0;
    feed_q.push_back(s);
    fed_bytes++;
    if (g_await) begin
      g_await = 1'b0;
      g_col = 0;
    end else begin
      if (g_col + 1 > g_hw) g_hw = g_col + 1;
      if (g_col + 1 >= clamp_len(g_len)) begin
        g_await = 1'b1;
        g_col = 0;
        g_row = (g_row + 1 >= clamp_rows(g_rows)) ? 0 : g_row + 1;
      end else begin
        g_col++;
      end
    end
  endtask

  task automatic push_cfg(input logic [pus_pkg::CFG_IDX_W-1:0] idx,
                          input logic [pus_pkg::CFG_DATA_W-1:0] v);
    feed_item_t s;
    s.op = OP_CFG;
    s.data = 8'h00;
    s.idx = idx;
    s.wdata = v;
    feed_q.push_back(s);
    if (idx == pus_pkg::CFG_ROW_LEN) g_len = v[pus_pkg::LEN_W-1:0];
    if (idx == pus_pkg::CFG_IMG_ROWS) g_rows = v[pus_pkg::ROWS_W-1:0];
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [7:0] pick_filter();
    case ($urandom_range(0, 5))
      0:       return pus_pkg::FILT_NONE;
      1:       return pus_pkg::FILT_SUB;
      2:       return pus_pkg::FILT_UP;
      3:       return pus_pkg::FILT_AVG;
      4:       return pus_pkg::FILT_PAETH;
      default: return $urandom_range(pus_pkg::FILT_PAETH + 1, 255);
    endcase
  endfunction

  // Finish the current row, or send a whole new one
  task automatic push_row();
    if (g_await) push_byte(pick_filter());
    while (!g_await) push_byte(pick_data());
  endtask

  task automatic run_phase(input logic [pus_pkg::CFG_DATA_W-1:0] bpp,
                           input logic [pus_pkg::CFG_DATA_W-1:0] len,
                           input logic [pus_pkg::CFG_DATA_W-1:0] rows,
                           input logic [2:0] mask);
    int unsigned span, nrows, lim;
    // row length may only grow past the written part of the store on a first row
    if (mask[1] && g_row != 0 && clamp_len(len[pus_pkg::LEN_W-1:0]) > g_hw) len = g_hw;
    if (mask[0]) push_cfg(pus_pkg::CFG_BPP, bpp);
    if (mask[1]) push_cfg(pus_pkg::CFG_ROW_LEN, len);
    if (mask[2]) push_cfg(pus_pkg::CFG_IMG_ROWS, rows);
    span = clamp_len(g_len) + 1;
    if (clamp_rows(g_rows) <= 6) nrows = clamp_rows(g_rows) * $urandom_range(1, 2);
    else nrows = $urandom_range(1, 6);
    if (nrows * span > 300) nrows = (300 / span > 0) ? 300 / span : 1;
    repeat (nrows) push_row();
    // sometimes stop mid-row so the next register write lands mid-stream
    if ($urandom_range(0, 3) == 0) begin
      lim = clamp_len(g_len) - 1;
      if (lim > 40) lim = 40;
      push_byte(pick_filter());
      repeat ($urandom_range(0, lim)) push_byte(pick_data());
    end
  endtask

  // Sender: one item at a time, config writes only once the block has drained
  always @(negedge clk) begin : feed_driver
    feed_item_t s;
    logic nxt_valid, nxt_we;
    bit hold_on;
    nxt_valid = in_valid && !in_fire;
    nxt_we = 1'b0;
    hold_on = (out_count % HOLD_EVERY == HOLD_AT);
    if (rst_n && !nxt_valid) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (feed_q.size() > 0) begin
        s = feed_q[0];
        if (s.op == OP_BYTE) begin
          void'(feed_q.pop_front());
          in_stream_byte <= s.data;
          nxt_valid = 1'b1;
          draw_gap(tx_run, tx_calm, tx_gap);
          // keep offering while the receiver holds off
          if (hold_on) tx_gap = 0;
        end else if (recon_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
          void'(feed_q.pop_front());
          cfg_index <= s.idx;
          cfg_wdata <= s.wdata;
          nxt_we = 1'b1;
          case (s.idx)
            pus_pkg::CFG_BPP:      p_bpp = s.wdata[pus_pkg::BPP_W-1:0];
            pus_pkg::CFG_ROW_LEN:  p_len = s.wdata[pus_pkg::LEN_W-1:0];
            pus_pkg::CFG_IMG_ROWS: p_rows = s.wdata[pus_pkg::ROWS_W-1:0];
            default:               ;
          endcase
        end
      end
    end
    in_valid <= nxt_valid;
    cfg_we <= nxt_we;
  end

  // Receiver: random stalls, with a long hold now and then to back up the block
  always @(negedge clk) begin : result_sink
    if (out_fire) begin
      if (out_count % HOLD_EVERY == HOLD_AT) rx_gap = HOLD_CYCLES;
      else draw_gap(rx_run, rx_calm, rx_gap);
    end else if (rx_gap > 0) begin
      rx_gap--;
    end
    out_stall <= (rx_gap > 0);
  end

  // Monitor: handshakes, result check, prediction and watchdog
  always @(posedge clk) begin : observe
    pixel_t got, want;
    in_fire = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    // check before predicting: a result never belongs to this cycle's input
    if (out_fire) begin
      got = {out_pixel_byte, out_row_end, out_image_end};
      if (recon_q.size() == 0) begin
        if (err_count < 10)
          $display("unexpected result %0d: pixel %02h row_end %0b image_end %0b",
                   out_count, got.pixel, got.row_end, got.image_end);
        err_count++;
      end else begin
        want = recon_q.pop_front();
        if (got !== want) begin
          if (err_count < 10)
            $display("mismatch at result %0d: pixel %02h row_end %0b image_end %0b, %s",
                     out_count, got.pixel, got.row_end, got.image_end,
                     $sformatf("expected pixel %02h row_end %0b image_end %0b",
                               want.pixel, want.row_end, want.image_end));
          err_count++;
        end
      end
      out_count++;
    end
    if (in_fire) begin
      unfilter_step(in_stream_byte);
      taken_bytes++;
      quiet_cycles = 0;
    end else if (quiet_cycles < 1000) begin
      quiet_cycles++;
    end
    if (!rst_n || in_fire || out_fire || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("png_scanline_unfilter_core regression: fail");
        $finish;
      end
    end
  end

  initial begin : run
    int unsigned base, phase;
    logic [pus_pkg::CFG_DATA_W-1:0] bpp, len, rows;

    // defaults after reset: 1 byte rows, one row per image, all operands zero
    push_byte(pus_pkg::FILT_PAETH);
    push_byte(8'hFF);

    // sub, up, average and Paeth over a 2-byte-pixel image, first row then three with an up row
    push_cfg(pus_pkg::CFG_BPP, 2);
    push_cfg(pus_pkg::CFG_ROW_LEN, 3);
    push_cfg(pus_pkg::CFG_IMG_ROWS, 4);
    push_byte(pus_pkg::FILT_SUB);   push_byte(8'h80); push_byte(8'h7F); push_byte(8'hFF);
    push_byte(pus_pkg::FILT_UP);    push_byte(8'hFF); push_byte(8'h01); push_byte(8'h00);
    push_byte(pus_pkg::FILT_AVG);   push_byte(8'hFF); push_byte(8'h00); push_byte(8'h55);
    push_byte(pus_pkg::FILT_PAETH); push_byte(8'h00); push_byte(8'hFF); push_byte(8'h80);

    // unknown code passes bytes through; row length shrinks below the column mid-row
    push_cfg(pus_pkg::CFG_IMG_ROWS, 2);
    push_byte(8'hFF);               push_byte(8'h12); push_byte(8'h34); push_byte(8'h56);
    push_byte(pus_pkg::FILT_PAETH); push_byte(8'h01);
    push_cfg(pus_pkg::CFG_ROW_LEN, 1);
    push_byte(8'h02);

    // random phases, split by a single-row image with over-range length
    phase = 0;
    for (int part = 0; part < 2; part++) begin
      base = fed_bytes;
      while (fed_bytes - base < RANDOM_BYTES / 2) begin
        case (phase)
          0: run_phase(0, 0, 0, 3'b111);
          1: run_phase(pus_pkg::MAX_BPP, 5, 16'hFFFF, 3'b111);
          default: begin
            case ($urandom_range(0, 7))
              0:       bpp = 0;
              1:       bpp = $urandom_range(pus_pkg::MAX_BPP + 1, 7);
              default: bpp = $urandom_range(1, pus_pkg::MAX_BPP);
            endcase
            case ($urandom_range(0, 9))
              0:       len = 0;
              1:       len = 1;
              2, 3, 4: len = $urandom_range(2, 8);
              5, 6, 7: len = $urandom_range(9, 40);
              default: len = $urandom_range(41, 120);
            endcase
            case ($urandom_range(0, 7))
              0:       rows = 0;
              1:       rows = 16'hFFFF;
              2:       rows = $urandom_range(7, 65534);
              default: rows = $urandom_range(1, 6);
            endcase
            run_phase(bpp, len, rows, $urandom_range(1, 7));
          end
        endcase
        phase++;
      end
      if (part == 0) begin
        push_cfg(pus_pkg::CFG_IMG_ROWS, 1);
        if (!g_await || g_row != 0) push_row();
        push_cfg(pus_pkg::CFG_BPP, 7);
        push_cfg(pus_pkg::CFG_ROW_LEN, 16'h3FFF);
        // long row that does not end early, then cut short mid-row
        push_byte(pick_filter());
        repeat (LONG_BYTES) push_byte(pick_data());
        push_cfg(pus_pkg::CFG_ROW_LEN, 40);
        push_row();
      end
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() != 0 || taken_bytes != fed_bytes || recon_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0 && recon_q.size() == 0) begin
      $display("png_scanline_unfilter_core regression: pass");
    end else begin
      $display("png_scanline_unfilter_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
